// File: hdl/bcps_pkg.sv
`timescale 1ns / 1ps
package bcps_pkg;

  // Search grid and number formats.
  localparam int N_COARSE     = 100;
  localparam int N_FINE       = 100;
  localparam int T_FRAC_BITS  = 16;
  localparam int TW           = T_FRAC_BITS + 1;
  localparam int CW           = 24;
  localparam int SQW          = 50;
  localparam int ROOTW        = 25;
  localparam int STEPW        = 8;

  localparam logic [TW-1:0]    T_ONE   = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0]    QSTEP_C = TW'((64'd1 << T_FRAC_BITS) / N_COARSE);
  localparam logic [STEPW-1:0] RSTEP_C = STEPW'((64'd1 << T_FRAC_BITS) % N_COARSE);
  localparam logic [TW-1:0]    R_SPAN  = QSTEP_C;
  localparam logic [STEPW-1:0] DIV_C   = STEPW'(N_COARSE);
  localparam logic [STEPW-1:0] DIV_F   = STEPW'(N_FINE);

  // Configuration register indexes.
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_CTRL_X  = 3'd2;
  localparam logic [2:0] REG_CTRL_Y  = 3'd3;
  localparam logic [2:0] REG_END_X   = 3'd4;
  localparam logic [2:0] REG_END_Y   = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
  } in_t;

  typedef struct packed {
    logic [TW-1:0]    best_param;
    logic [ROOTW-1:0] nearest_distance;
  } out_t;

  typedef struct packed {
    logic load_query;
    logic clear_best;
    logic init_coarse;
    logic fine_setup;
    logic div_step;
    logic init_fine;
    logic issue;
    logic sqrt_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_step;
    logic pipe_empty;
    logic div_done;
    logic sqrt_done;
  } ctrl_sts_t;

endpackage

// File: hdl/bcps_isqrt.sv
`timescale 1ns / 1ps
module bcps_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bcps_pkg::SQW-1:0]     radicand,
  output logic                         done,
  output logic [bcps_pkg::ROOTW-1:0]   root
);
  import bcps_pkg::*;

  localparam int CNTW = $clog2(ROOTW + 1);

  logic [SQW-1:0]  v_r, r_r, b_r;
  logic [SQW-1:0]  v_nxt, r_nxt, trial;
  logic [CNTW-1:0] cnt_r;
  logic            run_r, done_r;

  // One result bit per cycle, restoring form.
  always_comb begin
    trial = r_r + b_r;
    if (v_r >= trial) begin
      v_nxt = v_r - trial;
      r_nxt = (r_r >> 1) + b_r;
    end else begin
      v_nxt = v_r;
      r_nxt = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNTW'(ROOTW - 1);
        v_r   <= radicand;
        r_r   <= '0;
        b_r   <= SQW'(1) << (2 * (ROOTW - 1));
      end else if (run_r) begin
        v_r <= v_nxt;
        r_r <= r_nxt;
        b_r <= b_r >> 2;
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[ROOTW-1:0];
endmodule

// File: hdl/bcps_datapath.sv
`timescale 1ns / 1ps
module bcps_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bcps_pkg::ctrl_cmd_t    cmd,
  output bcps_pkg::ctrl_sts_t    sts,
  input  bcps_pkg::in_t          in_data,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [bcps_pkg::CW-1:0] cfg_data,
  output bcps_pkg::out_t         out_data
);
  import bcps_pkg::*;

  localparam int PW  = 2 * TW;
  localparam int WPW = TW + 1 + CW;
  localparam int BW  = WPW + 2 - T_FRAC_BITS;
  localparam int DW  = BW + 1;

  // Curve control points.
  logic signed [CW-1:0] p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r;
  logic signed [CW-1:0] qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0x_r <= '0; p0y_r <= '0; p1x_r <= '0;
      p1y_r <= '0; p2x_r <= '0; p2y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: p0x_r <= cfg_data;
        REG_START_Y: p0y_r <= cfg_data;
        REG_CTRL_X:  p1x_r <= cfg_data;
        REG_CTRL_Y:  p1y_r <= cfg_data;
        REG_END_X:   p2x_r <= cfg_data;
        REG_END_Y:   p2y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx_r <= in_data.query_x;
      qy_r <= in_data.query_y;
    end
  end

  // Parameter generator: t = lo + floor(span * k / div), kept as quotient and remainder.
  logic [TW-1:0]    lo_r, tq_r, qstep_r, dv_rem_r, best_r, t_cur;
  logic [STEPW-1:0] trem_r, rstep_r, div_r, cnt_r;
  logic [STEPW:0]   rem_sum;
  logic             wrap;
  logic [TW:0]      up_sum;
  logic [TW-1:0]    f_lo, f_hi;

  assign t_cur   = lo_r + tq_r;
  assign rem_sum = {1'b0, trem_r} + {1'b0, rstep_r};
  assign wrap    = rem_sum >= {1'b0, div_r};
  assign up_sum  = {1'b0, best_r} + {1'b0, R_SPAN};
  assign f_lo    = (best_r > R_SPAN) ? best_r - R_SPAN : '0;
  assign f_hi    = (up_sum < {1'b0, T_ONE}) ? up_sum[TW-1:0] : T_ONE;

  always_ff @(posedge clk) begin
    if (cmd.init_coarse) begin
      lo_r    <= '0;
      tq_r    <= '0;
      trem_r  <= '0;
      qstep_r <= QSTEP_C;
      rstep_r <= RSTEP_C;
      div_r   <= DIV_C;
      cnt_r   <= '0;
    end else if (cmd.fine_setup) begin
      lo_r     <= f_lo;
      dv_rem_r <= f_hi - f_lo;
      qstep_r  <= '0;
    end else if (cmd.div_step) begin
      dv_rem_r <= dv_rem_r - TW'(DIV_F);
      qstep_r  <= qstep_r + TW'(1);
    end else if (cmd.init_fine) begin
      tq_r    <= '0;
      trem_r  <= '0;
      rstep_r <= dv_rem_r[STEPW-1:0];
      div_r   <= DIV_F;
      cnt_r   <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + STEPW'(1);
      if (wrap) begin
        trem_r <= STEPW'(rem_sum - {1'b0, div_r});
        tq_r   <= tq_r + qstep_r + TW'(1);
      end else begin
        trem_r <= rem_sum[STEPW-1:0];
        tq_r   <= tq_r + qstep_r;
      end
    end
  end

  // Stage 1: weight products.
  logic [TW-1:0] u_cur;
  logic [PW-1:0] uu_r, ut_r, tt_r;
  logic [TW-1:0] t1_r, t2_r, t3_r, t4_r, t5_r;
  logic          v1_r, v2_r, v3_r, v4_r, v5_r;

  assign u_cur = T_ONE - t_cur;

  always_ff @(posedge clk) begin
    uu_r <= PW'(u_cur) * PW'(u_cur);
    ut_r <= PW'(u_cur) * PW'(t_cur);
    tt_r <= PW'(t_cur) * PW'(t_cur);
    t1_r <= t_cur;
  end

  // Stage 2: rounded weights.
  logic [PW:0]   wu_s, wm_s, wt_s;
  logic [TW-1:0] wu_r, wm_r, wt_r;

  assign wu_s = {1'b0, uu_r} + (PW+1)'(T_ONE >> 1);
  assign wm_s = {ut_r, 1'b0} + (PW+1)'(T_ONE >> 1);
  assign wt_s = {1'b0, tt_r} + (PW+1)'(T_ONE >> 1);

  always_ff @(posedge clk) begin
    wu_r <= wu_s[T_FRAC_BITS +: TW];
    wm_r <= wm_s[T_FRAC_BITS +: TW];
    wt_r <= wt_s[T_FRAC_BITS +: TW];
    t2_r <= t1_r;
  end

  // Stage 3: weights times control points.
  logic signed [TW:0]    swu, swm, swt;
  logic signed [WPW-1:0] ux_r, mx_r, tx_r, uy_r, my_r, ty_r;

  assign swu = $signed({1'b0, wu_r});
  assign swm = $signed({1'b0, wm_r});
  assign swt = $signed({1'b0, wt_r});

  always_ff @(posedge clk) begin
    ux_r <= WPW'(swu) * WPW'(p0x_r);
    mx_r <= WPW'(swm) * WPW'(p1x_r);
    tx_r <= WPW'(swt) * WPW'(p2x_r);
    uy_r <= WPW'(swu) * WPW'(p0y_r);
    my_r <= WPW'(swm) * WPW'(p1y_r);
    ty_r <= WPW'(swt) * WPW'(p2y_r);
    t3_r <= t2_r;
  end

  // Stage 4: curve point, rounded half up, minus the query.
  logic signed [WPW+1:0] sx, sy;
  logic signed [BW-1:0]  bx, by;
  logic signed [DW-1:0]  dx_r, dy_r;

  assign sx = WPW'(0) + (WPW+2)'(ux_r) + (WPW+2)'(mx_r) + (WPW+2)'(tx_r)
              + (WPW+2)'(T_ONE >> 1);
  assign sy = (WPW+2)'(uy_r) + (WPW+2)'(my_r) + (WPW+2)'(ty_r)
              + (WPW+2)'(T_ONE >> 1);
  assign bx = BW'(sx >>> T_FRAC_BITS);
  assign by = BW'(sy >>> T_FRAC_BITS);

  always_ff @(posedge clk) begin
    dx_r <= DW'(bx) - DW'(qx_r);
    dy_r <= DW'(by) - DW'(qy_r);
    t4_r <= t3_r;
  end

  // Stage 5: squares.
  logic signed [2*DW-1:0] dx2, dy2;
  logic [SQW-1:0]         dx2_r, dy2_r;

  assign dx2 = dx_r * dx_r;
  assign dy2 = dy_r * dy_r;

  always_ff @(posedge clk) begin
    dx2_r <= dx2[SQW-1:0];
    dy2_r <= dy2[SQW-1:0];
    t5_r  <= t4_r;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Keep the first strict minimum.
  logic [SQW:0]   d_sum;
  logic [SQW-1:0] min_r;

  assign d_sum = {1'b0, dx2_r} + {1'b0, dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      min_r  <= '1;
    end else if (cmd.clear_best) begin
      best_r <= '0;
      min_r  <= '1;
    end else if (v5_r && (d_sum < {1'b0, min_r})) begin
      best_r <= t5_r;
      min_r  <= d_sum[SQW-1:0];
    end
  end

  // Square root of the winning distance.
  logic             sq_done;
  logic [ROOTW-1:0] root;

  bcps_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (min_r),
    .done     (sq_done),
    .root     (root)
  );

  assign sts.last_step  = (cnt_r == div_r);
  assign sts.pipe_empty = !(v1_r || v2_r || v3_r || v4_r || v5_r);
  assign sts.div_done   = (dv_rem_r < TW'(DIV_F));
  assign sts.sqrt_done  = sq_done;

  assign out_data.best_param       = best_r;
  assign out_data.nearest_distance = root;
endmodule

// File: hdl/bcps_ctrl.sv
`timescale 1ns / 1ps
module bcps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output bcps_pkg::ctrl_cmd_t  cmd,
  input  bcps_pkg::ctrl_sts_t  sts
);
  import bcps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COARSE, ST_DRAIN_C, ST_FSETUP, ST_FDIV,
    ST_FINE, ST_DRAIN_F, ST_SQRT, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Command decode and next state.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_query  = 1'b1;
          cmd.clear_best  = 1'b1;
          cmd.init_coarse = 1'b1;
          state_nxt       = ST_COARSE;
        end
      end
      ST_COARSE: begin
        cmd.issue = 1'b1;
        if (sts.last_step) state_nxt = ST_DRAIN_C;
      end
      ST_DRAIN_C: begin
        if (sts.pipe_empty) state_nxt = ST_FSETUP;
      end
      ST_FSETUP: begin
        cmd.fine_setup = 1'b1;
        state_nxt      = ST_FDIV;
      end
      ST_FDIV: begin
        if (sts.div_done) begin
          cmd.init_fine = 1'b1;
          state_nxt     = ST_FINE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINE: begin
        cmd.issue = 1'b1;
        if (sts.last_step) state_nxt = ST_DRAIN_F;
      end
      ST_DRAIN_F: begin
        if (sts.pipe_empty) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);
endmodule

// File: hdl/bezier_closest_point_search_unit.sv
`timescale 1ns / 1ps
// Operation: 101 coarse and then 101 fine curve points go through a five-stage evaluation
// pipeline one per cycle. Each pass drains before the next step; the fine span division runs
// between the two passes, and the bit-serial square root runs after the fine pass, before the
// out_valid strobe.
// One item per search: a new item is taken only while idle, and busy stays high
// through the result strobe. Reset (rst_n low, synchronous) returns the controller to idle
// and clears the curve registers.
module bezier_closest_point_search_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  bcps_pkg::in_t           in_data,
  output logic                    out_valid,
  output bcps_pkg::out_t          out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [bcps_pkg::CW-1:0] cfg_data
);
  import bcps_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      busy_i;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  bcps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && !busy_i),
    .busy  (busy_i),
    .done  (out_valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  bcps_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  assign busy = busy_i;
endmodule

// File: hdl/bcps_checker.sv
`timescale 1ns / 1ps
module bcps_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input bcps_pkg::out_t out_data
);
  import bcps_pkg::*;

  // A result strobe lasts one cycle and ends the search.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy) else $error("result strobe not single");

  // A result only appears during a search.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside search");

  // An accepted item starts a search.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid) else $error("accept did not start search");

  // The parameter never exceeds one.
  a_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_param <= T_ONE) else $error("parameter out of range");
endmodule

bind bezier_closest_point_search_unit bcps_checker u_bcps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
